### sv/plfc_pkg.sv
// ----------------------------------------------------------------------------
// plfc_pkg
// Shared types and constants of the PMBus LINEAR11/LINEAR16 format converter.
// ----------------------------------------------------------------------------
package plfc_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned VAL_W   = 48;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned MANT_W  = 11;

  // conversion codes
  typedef enum logic [OP_W-1:0] {
    OP_DEC_L11 = 2'd0,
    OP_ENC_L11 = 2'd1,
    OP_DEC_L16 = 2'd2,
    OP_ENC_L16 = 2'd3
  } op_e;

  // fixed-point range limits
  localparam logic [VAL_W-1:0] VAL_POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_NEG_MAG = {1'b1, {(VAL_W-1){1'b0}}};

  // linear11 limits
  localparam logic [MANT_W-1:0] MANT_MAX     = 11'd1023;
  localparam logic [MANT_W:0]   MANT_MODULUS = 12'd2048;
  localparam int                EXP_LO       = -15;
  localparam int                EXP_HI       = 15;

  // linear16 limit
  localparam logic [WORD_W-1:0] L16_MAX = 16'hFFFF;

  // vout_mode exponent after reset
  localparam logic [EXP_W-1:0] VOUT_EXP_RESET = 5'b10111;

endpackage

### sv/pmbus_linear_format_converter.sv
// ----------------------------------------------------------------------------
// pmbus_linear_format_converter
// Converts PMBus LINEAR11/LINEAR16 words to and from signed fixed-point values.
// ----------------------------------------------------------------------------
// Timing: a word taken into the input register is converted combinationally
//   and registered in the result register; done_o is high for one cycle.
// Throughput: one word per cycle; busy is never raised, the input register
//   and the result register bound a single combinational conversion pass.
// Stalls: none; the receiver cannot hold results off.
// Reset: rst_ni clears the pipeline valid flags and loads vout_exponent = -9.
// ----------------------------------------------------------------------------
module pmbus_linear_format_converter #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [plfc_pkg::OP_W-1:0]         op_i,
  input  logic [plfc_pkg::WORD_W-1:0]       word_in_i,
  input  logic signed [plfc_pkg::VAL_W-1:0] value_in_i,
  // result channel
  output logic                              done_o,
  output logic [plfc_pkg::WORD_W-1:0]       word_out_o,
  output logic signed [plfc_pkg::VAL_W-1:0] value_out_o,
  // vout_mode exponent write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [plfc_pkg::EXP_W-1:0] cfg_vout_exponent_i
);

  import plfc_pkg::*;

  // largest shift used by any conversion
  localparam int unsigned SH_MAX = EXP_HI + FRACTION_BITS;
  localparam int unsigned SH_W   = $clog2(SH_MAX + 1);
  localparam int unsigned MAG_W  = WORD_W + 1;
  localparam int unsigned SCL_W  = MAG_W + SH_MAX;
  localparam int unsigned POS_W  = $clog2(VAL_W);

  // input register
  logic              vld_q;
  op_e               op_q;
  logic [WORD_W-1:0] word_q;
  logic [VAL_W-1:0]  value_q;

  // configuration register
  logic [EXP_W-1:0]  vout_exp_q;

  // result register
  logic              done_q;
  logic [WORD_W-1:0] word_out_q, word_out_d;
  logic [VAL_W-1:0]  value_out_q, value_out_d;

  // decode path
  logic [MANT_W-1:0] l11_mant;
  logic [MANT_W:0]   l11_mag;
  logic [MAG_W-1:0]  dec_mag;
  logic              dec_neg;
  logic [EXP_W-1:0]  dec_exp;
  logic signed [7:0] dec_sh_s;
  logic [SH_W-1:0]   dec_sh;
  logic [SCL_W-1:0]  dec_scaled;
  logic [SCL_W-1:0]  dec_lim;
  logic [VAL_W-1:0]  dec_res;
  logic [VAL_W-1:0]  dec_val;

  // encode path
  logic              enc_neg;
  logic [VAL_W-1:0]  enc_abs;
  logic [POS_W-1:0]  lead_pos;
  logic signed [7:0] e_raw;
  logic signed [7:0] e_clip;
  logic signed [7:0] r11_s;
  logic [SH_W-1:0]   r11;
  logic [VAL_W-1:0]  q11;
  logic              rem_nz;
  logic [MANT_W:0]   mag11_sum;
  logic [MANT_W-1:0] mag11;
  logic [MANT_W:0]   neg_mant;
  logic [MANT_W-1:0] mant11;
  logic [WORD_W-1:0] enc11_word;
  logic signed [7:0] r16_s;
  logic [SH_W-1:0]   r16;
  logic [VAL_W-1:0]  q16;
  logic [WORD_W-1:0] enc16_word;

  // the converter never stalls a command or a register write
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q    <= op_e'(op_i);
      word_q  <= word_in_i;
      value_q <= value_in_i;
    end
  end

  // vout_mode exponent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_exp_q <= VOUT_EXP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vout_exp_q <= cfg_vout_exponent_i;
    end
  end

  // decode: sign/magnitude times 2^(exp + fraction bits), saturated
  always_comb begin
    l11_mant = word_q[MANT_W-1:0];
    l11_mag  = l11_mant[MANT_W-1] ? (MANT_MODULUS - {1'b0, l11_mant}) : {1'b0, l11_mant};
    if (op_q == OP_DEC_L11) begin
      dec_mag = MAG_W'(l11_mag);
      dec_neg = l11_mant[MANT_W-1];
      dec_exp = word_q[WORD_W-1:MANT_W];
    end else begin
      dec_mag = MAG_W'(word_q);
      dec_neg = 1'b0;
      dec_exp = vout_exp_q;
    end
    dec_sh_s   = {{(8-EXP_W){dec_exp[EXP_W-1]}}, dec_exp} + 8'(FRACTION_BITS);
    dec_sh     = dec_sh_s[7] ? '0 : dec_sh_s[SH_W-1:0];
    dec_scaled = SCL_W'(dec_mag) << dec_sh;
    dec_lim    = dec_neg ? SCL_W'(VAL_NEG_MAG) : SCL_W'(VAL_POS_MAX);
    dec_res    = (dec_scaled > dec_lim) ? dec_lim[VAL_W-1:0] : dec_scaled[VAL_W-1:0];
    dec_val    = dec_neg ? ('0 - dec_res) : dec_res;
  end

  // encode: magnitude and leading one
  always_comb begin
    enc_neg  = value_q[VAL_W-1];
    enc_abs  = enc_neg ? ('0 - value_q) : value_q;
    lead_pos = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (enc_abs[i]) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  // linear11 encode: normalize into 512..1023, exponent held to -15..15
  always_comb begin
    e_raw  = 8'(lead_pos) - 8'(FRACTION_BITS + 9);
    if (e_raw < 8'(EXP_LO)) begin
      e_clip = 8'(EXP_LO);
    end else if (e_raw > 8'(EXP_HI)) begin
      e_clip = 8'(EXP_HI);
    end else begin
      e_clip = e_raw;
    end
    r11_s  = e_clip + 8'(FRACTION_BITS);
    r11    = r11_s[7] ? '0 : r11_s[SH_W-1:0];
    q11    = enc_abs >> r11;
    rem_nz = |(enc_abs & ~({VAL_W{1'b1}} << r11));
    // round toward minus infinity: negative values round the magnitude up
    if (|q11[VAL_W-1:MANT_W-1]) begin
      mag11_sum = {1'b0, MANT_MAX};
    end else begin
      mag11_sum = {2'b00, q11[MANT_W-2:0]} + {{MANT_W{1'b0}}, enc_neg && rem_nz};
    end
    mag11    = (mag11_sum > {1'b0, MANT_MAX}) ? MANT_MAX : mag11_sum[MANT_W-1:0];
    neg_mant = MANT_MODULUS - {1'b0, mag11};
    mant11   = enc_neg ? neg_mant[MANT_W-1:0] : mag11;
    if (q11 == '0) begin
      enc11_word = '0;
    end else begin
      enc11_word = {e_clip[EXP_W-1:0], mant11};
    end
  end

  // linear16 encode: floor, saturate, negative gives zero
  always_comb begin
    r16_s = {{(8-EXP_W){vout_exp_q[EXP_W-1]}}, vout_exp_q} + 8'(FRACTION_BITS);
    r16   = r16_s[7] ? '0 : r16_s[SH_W-1:0];
    q16   = enc_abs >> r16;
    if (enc_neg) begin
      enc16_word = '0;
    end else if (|q16[VAL_W-1:WORD_W]) begin
      enc16_word = L16_MAX;
    end else begin
      enc16_word = q16[WORD_W-1:0];
    end
  end

  // result select
  always_comb begin
    word_out_d  = '0;
    value_out_d = '0;
    unique case (op_q)
      OP_DEC_L11: value_out_d = dec_val;
      OP_ENC_L11: word_out_d  = enc11_word;
      OP_DEC_L16: value_out_d = dec_val;
      OP_ENC_L16: word_out_d  = enc16_word;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      word_out_q  <= word_out_d;
      value_out_q <= value_out_d;
    end
  end

  assign done_o      = done_q;
  assign word_out_o  = word_out_q;
  assign value_out_o = value_out_q;

  // checks
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |=> done_o)
    else $error("conversion in flight produced no result strobe");

  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q))
    else $error("result strobe without a conversion in flight");

  a_decode_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && (op_q == OP_DEC_L11 || op_q == OP_DEC_L16) |=> word_out_o == '0)
    else $error("decode result carries a nonzero word");

  a_encode_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && (op_q == OP_ENC_L11 || op_q == OP_ENC_L16) |=> value_out_o == '0)
    else $error("encode result carries a nonzero value");

  a_l11_neg_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && op_q == OP_DEC_L11 && word_q[MANT_W-1] |=> value_out_o[VAL_W-1])
    else $error("negative linear11 mantissa decoded to a nonnegative value");

endmodule

### tb/pmbus_linear_format_converter_test.sv
// ----------------------------------------------------------------------------
// pmbus_linear_format_converter_test
// Self-checking bench for the LINEAR11/LINEAR16 converter: a queue-fed driver
// issues conversion words and VOUT_MODE exponent writes, a local predictor
// computes each result, and a monitor checks every done_o word against it.
// ----------------------------------------------------------------------------
module pmbus_linear_format_converter_test;
  import plfc_pkg::*;

  localparam int FRACTION_BITS = 16;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_WORDS   = 112;

  typedef enum logic {CMD_CONVERT, CMD_SET_EXP} cmd_kind_e;

  typedef struct {
    cmd_kind_e         kind;
    op_e               op;
    logic [WORD_W-1:0] word;
    logic [VAL_W-1:0]  value;
    logic [EXP_W-1:0]  vexp;
    int unsigned       gap;
  } conv_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] word_out;
    logic [VAL_W-1:0]  value_out;
  } conv_result_t;

  // dut ports, all inputs known from time zero
  logic                     clk_i               = 1'b0;
  logic                     rst_ni              = 1'b0;
  logic                     start               = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          op_i                = '0;
  logic [WORD_W-1:0]        word_in_i           = '0;
  logic signed [VAL_W-1:0]  value_in_i          = '0;
  logic                     done_o;
  logic [WORD_W-1:0]        word_out_o;
  logic signed [VAL_W-1:0]  value_out_o;
  logic                     cfg_valid_i         = 1'b0;
  logic                     cfg_ready_o;
  logic signed [EXP_W-1:0]  cfg_vout_exponent_i = '0;

  // bench state
  conv_cmd_t               pending_cmds[$];
  conv_result_t            expected_results[$];
  logic signed [EXP_W-1:0] vout_exp = VOUT_EXP_RESET;
  int unsigned             gap_left = 0;
  logic                    gap_armed = 1'b0;
  int unsigned             failures = 0;
  int unsigned             stall_cycles = 0;

  pmbus_linear_format_converter #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .op_i               (op_i),
    .word_in_i          (word_in_i),
    .value_in_i         (value_in_i),
    .done_o             (done_o),
    .word_out_o         (word_out_o),
    .value_out_o        (value_out_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vout_exponent_i(cfg_vout_exponent_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sign and magnitude times 2^shift, saturated to the fixed-point range
  function automatic logic [VAL_W-1:0] scale_fixed(logic neg, logic [63:0] mag, int shift);
    logic [63:0] lim;
    logic [63:0] scaled;
    lim = neg ? 64'(VAL_NEG_MAG) : 64'(VAL_POS_MAX);
    if (mag == 0) return '0;
    if (shift < 0) shift = 0;
    scaled = mag << shift;
    if (scaled > lim) scaled = lim;
    return neg ? VAL_W'(64'd0 - scaled) : VAL_W'(scaled);
  endfunction

  // linear11 encode of a sign and magnitude
  function automatic logic [WORD_W-1:0] encode_l11(logic neg, logic [VAL_W-1:0] mag);
    int               lead;
    int               expo;
    int               rsh;
    logic [VAL_W-1:0] quo;
    logic [VAL_W-1:0] rem;
    logic [MANT_W-1:0] mant;
    if (mag == 0) return '0;
    lead = 0;
    for (int i = 0; i < VAL_W; i++) if (mag[i]) lead = i;
    // bring the leading one to mantissa bit 9
    expo = lead - FRACTION_BITS - 9;
    if (expo < EXP_LO) expo = EXP_LO;
    if (expo > EXP_HI) expo = EXP_HI;
    rsh = expo + FRACTION_BITS;
    quo = mag >> rsh;
    rem = mag & ((VAL_W'(1) << rsh) - VAL_W'(1));
    if (quo == 0) return '0;
    // floor of a negative value rounds the magnitude up
    if (neg && rem != 0) quo = quo + VAL_W'(1);
    if (quo > VAL_W'(MANT_MAX)) quo = VAL_W'(MANT_MAX);
    mant = neg ? MANT_W'(VAL_W'(MANT_MODULUS) - quo) : MANT_W'(quo);
    return {EXP_W'(expo), mant};
  endfunction

  // linear16 encode, floor and saturate, negatives give zero
  function automatic logic [WORD_W-1:0] encode_l16(logic neg, logic [VAL_W-1:0] mag,
                                                   logic signed [EXP_W-1:0] vexp);
    int               rsh;
    logic [VAL_W-1:0] quo;
    if (neg) return '0;
    rsh = int'(vexp) + FRACTION_BITS;
    if (rsh < 0) rsh = 0;
    quo = mag >> rsh;
    return (quo > VAL_W'(L16_MAX)) ? L16_MAX : WORD_W'(quo);
  endfunction

  // expected conversion result for one command word
  function automatic conv_result_t convert(op_e op, logic [WORD_W-1:0] word,
                                           logic [VAL_W-1:0] value,
                                           logic signed [EXP_W-1:0] vexp);
    conv_result_t     res;
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic [63:0]      mant_mag;
    neg = value[VAL_W-1];
    mag = neg ? (VAL_W'(0) - value) : value;
    res.word_out  = '0;
    res.value_out = '0;
    case (op)
      OP_DEC_L11: begin
        mant_mag = word[MANT_W-1] ? 64'(MANT_MODULUS) - 64'(word[MANT_W-1:0])
                                  : 64'(word[MANT_W-1:0]);
        res.value_out = scale_fixed(word[MANT_W-1], mant_mag,
                                    int'($signed(word[WORD_W-1:MANT_W])) + FRACTION_BITS);
      end
      OP_ENC_L11: res.word_out = encode_l11(neg, mag);
      OP_DEC_L16: res.value_out = scale_fixed(1'b0, 64'(word), int'(vexp) + FRACTION_BITS);
      default:    res.word_out = encode_l16(neg, mag, vexp);
    endcase
    return res;
  endfunction

  task automatic queue_convert(op_e op, logic [WORD_W-1:0] word, logic [VAL_W-1:0] value,
                               int unsigned gap);
    conv_cmd_t cmd;
    cmd.kind  = CMD_CONVERT;
    cmd.op    = op;
    cmd.word  = word;
    cmd.value = value;
    cmd.vexp  = '0;
    cmd.gap   = gap;
    pending_cmds.push_back(cmd);
  endtask

  task automatic queue_set_exp(logic [EXP_W-1:0] vexp, int unsigned gap);
    conv_cmd_t cmd;
    cmd.kind  = CMD_SET_EXP;
    cmd.op    = OP_DEC_L11;
    cmd.word  = '0;
    cmd.value = '0;
    cmd.vexp  = vexp;
    cmd.gap   = gap;
    pending_cmds.push_back(cmd);
  endtask

  // driver: one nonblocking write per signal per edge
  always @(posedge clk_i or negedge rst_ni) begin
    conv_cmd_t head;
    logic      nxt_start;
    logic      nxt_cfg;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    = 0;
      gap_armed   = 1'b0;
      vout_exp    = VOUT_EXP_RESET;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid_i;
      if (start && !busy) begin
        expected_results.push_back(convert(op_e'(op_i), word_in_i, value_in_i, vout_exp));
        nxt_start = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        vout_exp = cfg_vout_exponent_i;
        nxt_cfg  = 1'b0;
      end
      if (!nxt_start && !nxt_cfg && pending_cmds.size() != 0) begin
        head = pending_cmds[0];
        if (!gap_armed) begin
          gap_left  = head.gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (head.kind == CMD_CONVERT) begin
          op_i       <= head.op;
          word_in_i  <= head.word;
          value_in_i <= head.value;
          nxt_start  = 1'b1;
          gap_armed  = 1'b0;
          void'(pending_cmds.pop_front());
        end else if (expected_results.size() == 0) begin
          // exponent only changes once every word in flight has come back
          cfg_vout_exponent_i <= head.vexp;
          nxt_cfg   = 1'b1;
          gap_armed = 1'b0;
          void'(pending_cmds.pop_front());
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: word_out=%h value_out=%h", word_out_o, value_out_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (word_out_o !== want.word_out) begin
          $error("word_out: expected %h, actual %h", want.word_out, word_out_o);
          failures++;
        end
        if (value_out_o !== want.value_out) begin
          $error("value_out: expected %h, actual %h", want.value_out, value_out_o);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    logic [VAL_W-1:0]  mag;
    logic [VAL_W-1:0]  value;
    logic [WORD_W-1:0] word;
    logic [EXP_W-1:0]  vexp;
    int unsigned       sh;
    int unsigned       gap;
    bit                idle_on;

    // decode extremes at the reset exponent
    queue_convert(OP_DEC_L11, 16'h0000, '0, 0);
    queue_convert(OP_DEC_L11, 16'hFFFF, '0, 0);
    queue_convert(OP_DEC_L11, 16'h7BFF, '0, 0);  // exponent 15, mantissa 1023
    queue_convert(OP_DEC_L11, 16'h7C00, '0, 1);  // exponent 15, mantissa -1024
    queue_convert(OP_DEC_L11, 16'h83FF, '0, 0);  // exponent -16, mantissa 1023
    queue_convert(OP_DEC_L11, 16'h8400, '0, 0);  // exponent -16, mantissa -1024
    queue_convert(OP_DEC_L16, 16'h0000, '0, 0);
    queue_convert(OP_DEC_L16, 16'hFFFF, '0, 2);
    // linear11 encode corners
    queue_convert(OP_ENC_L11, '0, '0, 0);                     // zero value
    queue_convert(OP_ENC_L11, '0, 48'd1, 0);                  // tiny positive
    queue_convert(OP_ENC_L11, '0, -48'd1, 0);                 // negative tiny value
    queue_convert(OP_ENC_L11, '0, 48'd3, 0);                  // unnormalized at -15
    queue_convert(OP_ENC_L11, '0, 48'h0000_03FF_8000, 0);     // 1023.5 stays at 2^0
    queue_convert(OP_ENC_L11, '0, -48'h0000_03FF_8000, 0);
    queue_convert(OP_ENC_L11, '0, 48'h0000_0200_0000, 3);     // exactly 512
    queue_convert(OP_ENC_L11, '0, VAL_POS_MAX, 0);            // exponent clamps at 15
    queue_convert(OP_ENC_L11, '0, VAL_NEG_MAG, 0);
    // linear16 encode corners
    queue_convert(OP_ENC_L16, '0, '0, 0);
    queue_convert(OP_ENC_L16, '0, -48'd5, 0);                 // negative gives zero
    queue_convert(OP_ENC_L16, '0, VAL_POS_MAX, 0);            // saturates
    queue_convert(OP_ENC_L16, '0, VAL_NEG_MAG, 0);
    queue_convert(OP_ENC_L16, '0, 48'h0000_0123_4567, 0);
    // exponent extremes
    queue_set_exp(5'b01111, 0);
    queue_convert(OP_DEC_L16, 16'hFFFF, '0, 0);               // decode overflow saturates
    queue_convert(OP_ENC_L16, '0, 48'h7FFF_8000_0000, 0);
    queue_set_exp(5'b10000, 0);
    queue_convert(OP_DEC_L16, 16'hFFFF, '0, 0);
    queue_convert(OP_ENC_L16, '0, 48'h0000_1234_5678, 0);

    // random phases, each opened by an exponent write
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)      vexp = 5'b10000;
      else if (ph == 1) vexp = 5'b01111;
      else              vexp = EXP_W'($urandom_range(0, 31));
      queue_set_exp(vexp, $urandom_range(0, 19));
      idle_on = (ph % 3) != 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        word = WORD_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0) begin
          // mantissa at one of its edges
          case ($urandom_range(0, 3))
            0:       word[MANT_W-1:0] = 11'h3FF;
            1:       word[MANT_W-1:0] = 11'h400;
            2:       word[MANT_W-1:0] = 11'h000;
            default: word[MANT_W-1:0] = 11'h7FF;
          endcase
        end
        case ($urandom_range(0, 7))
          0: mag = VAL_W'({$urandom, $urandom});
          1: begin
            // scaled magnitude just under 1024
            sh  = $urandom_range(1, 31);
            mag = (VAL_W'(MANT_MAX) << sh) |
                  (VAL_W'({$urandom, $urandom}) & ((VAL_W'(1) << sh) - VAL_W'(1)));
          end
          default: mag = VAL_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
        endcase
        value = $urandom_range(0, 1) ? (VAL_W'(0) - mag) : mag;
        gap   = idle_on ? $urandom_range(0, 19) : 0;
        queue_convert(op_e'($urandom_range(0, 3)), word, value, gap);
      end
    end

    // reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to drain and every result to come back
    while (pending_cmds.size() != 0 || start || cfg_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (failures == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
sv/plfc_pkg.sv
sv/pmbus_linear_format_converter.sv
tb/pmbus_linear_format_converter_test.sv
